// ===== design/keyed_bloom_filter_template_macros.svh =====
// Assertion macros used by the checker of this block.
`ifndef KEYED_BLOOM_FILTER_TEMPLATE_MACROS_SVH
`define KEYED_BLOOM_FILTER_TEMPLATE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define KBFT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define KBFT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/kbft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kbft_pkg;

   localparam int DEFAULT_WORD_BITS = 10;
   localparam int KEY_W             = 10;
   localparam int WORD_W            = 10;
   localparam int FILTER_WORD_W     = 64;
   localparam int BIT_SEL_W         = 6;
   localparam int WORD_INDEX_W      = 4;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_RUN,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== design/keyed_bloom_filter_template.sv =====
// A request marked last_word passes stages s1 and s2, and then the emit burst starts on rsp.
// Throughput: one request per cycle while req_stall is low; the emit burst issues a new slice
// only once the last one has left the filter memory read register for the output register (and
// rsp is not stalled), and holds req_stall meanwhile. Reset: synchronous, active high; afterwards a
// clearing pass of one slice per cycle over all slices runs before the first request is taken.
`timescale 1ns / 1ps
`default_nettype none

module keyed_bloom_filter_template #(
   parameter int WORD_BITS = kbft_pkg::DEFAULT_WORD_BITS
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_wr_en,
   input  wire  [kbft_pkg::KEY_W-1:0]            csr_wr_data,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [kbft_pkg::WORD_W-1:0]           req_word_bits,
   input  wire                                   req_last_word,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [kbft_pkg::FILTER_WORD_W-1:0]    rsp_filter_word,
   output logic [kbft_pkg::WORD_INDEX_W-1:0]     rsp_word_index,
   output logic                                  rsp_last_of_run
);

   localparam int XW      = (WORD_BITS > kbft_pkg::KEY_W) ? WORD_BITS : kbft_pkg::KEY_W;
   localparam int PW      = (WORD_BITS > kbft_pkg::BIT_SEL_W) ? WORD_BITS
                                                               : kbft_pkg::BIT_SEL_W + 1;
   localparam int SLICE_W = PW - kbft_pkg::BIT_SEL_W;
   localparam int SLICES  = (WORD_BITS > kbft_pkg::BIT_SEL_W) ? (1 << SLICE_W) : 1;
   localparam logic [SLICE_W-1:0] LAST_SLICE = SLICE_W'(SLICES - 1);

   localparam int FW = kbft_pkg::FILTER_WORD_W;
   localparam int BW = kbft_pkg::BIT_SEL_W;

   kbft_pkg::state_type state_ff, state_in;

   logic [kbft_pkg::KEY_W-1:0] key_ff, key_in;
   logic [SLICE_W-1:0]         sweep_ff, sweep_in;

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_last_ff, s1_last_in;
   logic [SLICE_W-1:0]         s1_slice_ff, s1_slice_in;
   logic [BW-1:0]              s1_bit_ff, s1_bit_in;

   logic                       s2_valid_ff, s2_valid_in;
   logic                       s2_last_ff, s2_last_in;
   logic [SLICE_W-1:0]         s2_slice_ff, s2_slice_in;
   logic [BW-1:0]              s2_bit_ff, s2_bit_in;

   logic                       wfwd_valid_ff, wfwd_valid_in;
   logic [SLICE_W-1:0]         wfwd_slice_ff, wfwd_slice_in;
   logic [FW-1:0]              wfwd_data_ff, wfwd_data_in;

   logic                       pend_ff, pend_in;
   logic [SLICE_W-1:0]         pend_slice_ff, pend_slice_in;
   logic                       pend_last_ff, pend_last_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]                     rsp_data_ff, rsp_data_in;
   logic [kbft_pkg::WORD_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic [FW-1:0]      mem [SLICES];
   logic [FW-1:0]      rdata_ff;
   logic               mem_we;
   logic [SLICE_W-1:0] mem_waddr;
   logic [SLICE_W-1:0] mem_raddr;
   logic [FW-1:0]      mem_wdata;

   logic               accept;
   logic               issue;
   logic [XW-1:0]      keyed;
   logic [PW-1:0]      pidx;
   logic               fwd_hit;
   logic [FW-1:0]      merged;

   always_comb begin
      keyed = XW'(req_word_bits ^ key_ff);
      pidx  = PW'(keyed[WORD_BITS-1:0]);
   end

   always_comb begin
      fwd_hit = wfwd_valid_ff && (wfwd_slice_ff == s2_slice_ff);
      merged  = rdata_ff | (FW'(1) << s2_bit_ff) | (fwd_hit ? wfwd_data_ff : '0);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kbft_pkg::ST_CLEAR: begin
            if (sweep_ff == LAST_SLICE) begin
               state_in = kbft_pkg::ST_RUN;
            end
         end
         kbft_pkg::ST_RUN: begin
            if (s2_valid_ff && s2_last_ff) begin
               state_in = kbft_pkg::ST_EMIT;
            end
         end
         kbft_pkg::ST_EMIT: begin
            if (issue && (sweep_ff == LAST_SLICE)) begin
               state_in = kbft_pkg::ST_RUN;
            end
         end
         default: state_in = kbft_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != kbft_pkg::ST_RUN) || (s1_valid_ff && s1_last_ff)
                  || (s2_valid_ff && s2_last_ff);
      accept    = req_valid && !req_stall;
      issue     = (state_ff == kbft_pkg::ST_EMIT) && !pend_ff
                  && (!rsp_valid_ff || !rsp_stall);
      mem_we    = 1'b0;
      mem_waddr = sweep_ff;
      mem_wdata = '0;
      mem_raddr = s1_slice_ff;
      sweep_in  = '0;
      case (state_ff)
         kbft_pkg::ST_CLEAR: begin
            mem_we   = 1'b1;
            sweep_in = sweep_ff + SLICE_W'(1);
         end
         kbft_pkg::ST_RUN: begin
            mem_we    = s2_valid_ff;
            mem_waddr = s2_slice_ff;
            mem_wdata = merged;
         end
         kbft_pkg::ST_EMIT: begin
            mem_we    = issue;
            mem_raddr = sweep_ff;
            sweep_in  = issue ? sweep_ff + SLICE_W'(1) : sweep_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      key_in        = csr_wr_en ? csr_wr_data : key_ff;
      s1_valid_in   = accept;
      s1_last_in    = req_last_word;
      s1_slice_in   = pidx[PW-1:BW];
      s1_bit_in     = pidx[BW-1:0];
      s2_valid_in   = s1_valid_ff;
      s2_last_in    = s1_last_ff;
      s2_slice_in   = s1_slice_ff;
      s2_bit_in     = s1_bit_ff;
      wfwd_valid_in = s2_valid_ff && (state_ff == kbft_pkg::ST_RUN);
      wfwd_slice_in = s2_slice_ff;
      wfwd_data_in  = merged;
      pend_in       = issue;
      pend_slice_in = sweep_ff;
      pend_last_in  = (sweep_ff == LAST_SLICE);
      rsp_valid_in  = pend_ff || (rsp_valid_ff && rsp_stall);
      rsp_data_in   = pend_ff ? rdata_ff : rsp_data_ff;
      rsp_index_in  = pend_ff ? kbft_pkg::WORD_INDEX_W'(pend_slice_ff) : rsp_index_ff;
      rsp_last_in   = pend_ff ? pend_last_ff : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kbft_pkg::ST_CLEAR;
         key_ff        <= '0;
         sweep_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         wfwd_valid_ff <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         key_ff        <= key_in;
         sweep_ff      <= sweep_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         wfwd_valid_ff <= wfwd_valid_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff    <= s1_last_in;
      s1_slice_ff   <= s1_slice_in;
      s1_bit_ff     <= s1_bit_in;
      s2_last_ff    <= s2_last_in;
      s2_slice_ff   <= s2_slice_in;
      s2_bit_ff     <= s2_bit_in;
      wfwd_slice_ff <= wfwd_slice_in;
      wfwd_data_ff  <= wfwd_data_in;
      pend_slice_ff <= pend_slice_in;
      pend_last_ff  <= pend_last_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_filter_word = rsp_data_ff;
   assign rsp_word_index  = rsp_index_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

// ===== design/kbft_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_bloom_filter_template_macros.svh"

module kbft_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_valid,
   input wire                                req_stall,
   input wire                                req_last_word,
   input wire                                rsp_valid,
   input wire                                rsp_stall,
   input wire [kbft_pkg::FILTER_WORD_W-1:0]  rsp_filter_word,
   input wire                                rsp_last_of_run
);

   `KBFT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")
   `KBFT_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_filter_word), "rsp data moved while stalled")
   `KBFT_ASSERT_NEXT(a_last_blocks, req_valid && !req_stall && req_last_word, req_stall, "request taken right after a last word")
   `KBFT_ASSERT_NOW(a_burst_blocks, rsp_valid && !rsp_last_of_run, req_stall, "request open during emit burst")

endmodule

bind keyed_bloom_filter_template kbft_checker u_kbft_checker (.*);

`default_nettype wire
